// ===== src/fourier_mode_phase_rotator_defines.svh =====
// Assertion macros used by the rotator top level.
`ifndef FOURIER_MODE_PHASE_ROTATOR_DEFINES_SVH
`define FOURIER_MODE_PHASE_ROTATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FMPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FMPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== src/fmpr_pkg.sv =====
`timescale 1ns / 1ps
package fmpr_pkg;
	localparam int MODE_W          = 10;
	localparam int MODE_COUNT_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int ANG_W        = 32;
	localparam int CS_W         = 32;
	localparam int CS_FRAC      = 30;
	localparam int Z_W          = 33;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [CS_W-1:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = 33'sd1073741824;
	localparam logic signed [Z_W-1:0]  HALF_TURN    = 33'sd2147483648;

	// atan(2^-i) as a binary angle, full turn = 2^32
	localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
		33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
		33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA,
		33'sh0000517D, 33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
		33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051, 33'sh00000029,
		33'sh00000014, 33'sh0000000A, 33'sh00000005, 33'sh00000003, 33'sh00000001
	};

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef struct packed {
		logic valid;
		logic mean_mode;
	} fmpr_tag_t;
endpackage

// ===== src/fmpr_stream_if.sv =====
`timescale 1ns / 1ps
interface fmpr_coef_if
	import fmpr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic        [MODE_W-1:0]      mode_number;
	logic signed [SAMPLE_BITS-1:0] real_part;
	logic signed [SAMPLE_BITS-1:0] imag_part;

	modport source (output valid, mode_number, real_part, imag_part, input ready);
	modport sink (input valid, mode_number, real_part, imag_part, output ready);
endinterface

interface fmpr_rot_if
	import fmpr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] rotated_real;
	logic signed [SAMPLE_BITS-1:0] rotated_imag;

	modport source (output valid, rotated_real, rotated_imag, input ready);
	modport sink (input valid, rotated_real, rotated_imag, output ready);
endinterface

// ===== src/fmpr_cordic.sv =====
`timescale 1ns / 1ps
module fmpr_cordic
	import fmpr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  fmpr_tag_t              tag_in,
	input  logic signed [Z_W-1:0]  z_in,
	input  logic                   flip_in,
	output fmpr_tag_t              tag_out,
	output logic signed [CS_W-1:0] x_out,
	output logic signed [CS_W-1:0] y_out,
	output logic                   flip_out
);
	// entry k holds the vector after k+1 micro-rotations
	fmpr_tag_t              tag_s  [CORDIC_STEPS];
	logic signed [CS_W-1:0] x_s    [CORDIC_STEPS];
	logic signed [CS_W-1:0] y_s    [CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_s    [CORDIC_STEPS];
	logic                   flip_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		fmpr_tag_t              tag_p;
		logic signed [CS_W-1:0] x_p, y_p, x_nx, y_nx;
		logic signed [Z_W-1:0]  z_p, z_nx;
		logic                   flip_p;

		if (i == 0) begin : g_first
			assign tag_p  = tag_in;
			assign x_p    = CORDIC_GAIN;
			assign y_p    = '0;
			assign z_p    = z_in;
			assign flip_p = flip_in;
		end else begin : g_next
			assign tag_p  = tag_s[i-1];
			assign x_p    = x_s[i-1];
			assign y_p    = y_s[i-1];
			assign z_p    = z_s[i-1];
			assign flip_p = flip_s[i-1];
		end

		always_comb begin
			if (z_p >= 0) begin
				x_nx = x_p - (y_p >>> i);
				y_nx = y_p + (x_p >>> i);
				z_nx = z_p - ATAN_TURNS[i];
			end else begin
				x_nx = x_p + (y_p >>> i);
				y_nx = y_p - (x_p >>> i);
				z_nx = z_p + ATAN_TURNS[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= x_nx;
				y_s[i]    <= y_nx;
				z_s[i]    <= z_nx;
				flip_s[i] <= flip_p;
			end
		end
	end

	assign tag_out  = tag_s[CORDIC_STEPS-1];
	assign x_out    = x_s[CORDIC_STEPS-1];
	assign y_out    = y_s[CORDIC_STEPS-1];
	assign flip_out = flip_s[CORDIC_STEPS-1];
endmodule

// ===== src/fmpr_cmac.sv =====
`timescale 1ns / 1ps
module fmpr_cmac
	import fmpr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  fmpr_tag_t                     tag_in,
	input  logic signed [CS_W-1:0]        x_in,
	input  logic signed [CS_W-1:0]        y_in,
	input  logic                          flip_in,
	input  logic signed [SAMPLE_BITS-1:0] re_in,
	input  logic signed [SAMPLE_BITS-1:0] im_in,
	output logic                          valid_out,
	output logic signed [SAMPLE_BITS-1:0] real_out,
	output logic signed [SAMPLE_BITS-1:0] imag_out
);
	// samples are split into a signed high part and an unsigned low part
	localparam int SPLIT = SAMPLE_BITS / 2;
	localparam int HI_W  = SAMPLE_BITS - SPLIT;
	localparam int LO_W  = SPLIT + 1;
	localparam int HP_W  = HI_W + CS_W;
	localparam int LP_W  = LO_W + CS_W;
	localparam int HS_W  = HP_W + 1;
	localparam int LS_W  = LP_W + 1;
	localparam int T_W   = HS_W + 1;

	localparam logic signed [LS_W-1:0] ROUND_BIAS = LS_W'(64'd1 << (CS_FRAC - 1));
	localparam logic signed [T_W-1:0]  OUT_MAX    =
		{{(T_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [T_W-1:0]  OUT_MIN    =
		{{(T_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [T_W-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		priority if (v > OUT_MAX) begin
			r = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	fmpr_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [CS_W-1:0]        c_s1, s_s1, ns_s1;
	logic signed [SAMPLE_BITS-1:0] re_s1, im_s1, re_s2, im_s2, re_s3, im_s3, re_s4, im_s4;
	logic signed [HP_W-1:0]        rhc_s2, ihs_s2, ihc_s2, rhn_s2;
	logic signed [LP_W-1:0]        rlc_s2, ils_s2, ilc_s2, rln_s2;
	logic signed [HS_W-1:0]        rhi_s3, ihi_s3;
	logic signed [LS_W-1:0]        rlo_s3, ilo_s3;
	logic signed [T_W-1:0]         rtot_s4, itot_s4;
	logic signed [SAMPLE_BITS-1:0] real_s5, imag_s5;

	logic signed [HI_W-1:0] re_hi, im_hi;
	logic signed [LO_W-1:0] re_lo, im_lo;
	logic signed [T_W-1:0]  rq, iq;

	assign re_hi = re_s1[SAMPLE_BITS-1:SPLIT];
	assign im_hi = im_s1[SAMPLE_BITS-1:SPLIT];
	assign re_lo = signed'({1'b0, re_s1[SPLIT-1:0]});
	assign im_lo = signed'({1'b0, im_s1[SPLIT-1:0]});

	assign rq = rtot_s4 >>> (CS_FRAC - SPLIT);
	assign iq = itot_s4 >>> (CS_FRAC - SPLIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// undo the half-turn fold
			c_s1  <= flip_in ? -x_in : x_in;
			s_s1  <= flip_in ? -y_in : y_in;
			ns_s1 <= flip_in ? y_in : -y_in;
			re_s1 <= re_in;
			im_s1 <= im_in;

			rhc_s2 <= HP_W'(re_hi) * HP_W'(c_s1);
			rlc_s2 <= LP_W'(re_lo) * LP_W'(c_s1);
			ihs_s2 <= HP_W'(im_hi) * HP_W'(s_s1);
			ils_s2 <= LP_W'(im_lo) * LP_W'(s_s1);
			ihc_s2 <= HP_W'(im_hi) * HP_W'(c_s1);
			ilc_s2 <= LP_W'(im_lo) * LP_W'(c_s1);
			rhn_s2 <= HP_W'(re_hi) * HP_W'(ns_s1);
			rln_s2 <= LP_W'(re_lo) * LP_W'(ns_s1);
			re_s2  <= re_s1;
			im_s2  <= im_s1;

			rhi_s3 <= HS_W'(rhc_s2) + HS_W'(ihs_s2);
			rlo_s3 <= LS_W'(rlc_s2) + LS_W'(ils_s2) + ROUND_BIAS;
			ihi_s3 <= HS_W'(ihc_s2) + HS_W'(rhn_s2);
			ilo_s3 <= LS_W'(ilc_s2) + LS_W'(rln_s2) + ROUND_BIAS;
			re_s3  <= re_s2;
			im_s3  <= im_s2;

			// floor of the low sum scaled back to the high weight
			rtot_s4 <= T_W'(rhi_s3) + T_W'(rlo_s3 >>> SPLIT);
			itot_s4 <= T_W'(ihi_s3) + T_W'(ilo_s3 >>> SPLIT);
			re_s4   <= re_s3;
			im_s4   <= im_s3;

			real_s5 <= tag_s4.mean_mode ? re_s4 : sat(rq);
			imag_s5 <= tag_s4.mean_mode ? im_s4 : sat(iq);
		end
	end

	assign valid_out = tag_s5.valid;
	assign real_out  = real_s5;
	assign imag_out  = imag_s5;
endmodule

// ===== src/fourier_mode_phase_rotator.sv =====
`timescale 1ns / 1ps
// Rotates one complex Fourier coefficient per clock by the angle -mode*phi
// (+mode*phi when direction_negative is set), phi being a binary angle
// with 2^32 per turn. Mode numbers wrap modulo MODE_COUNT; the mean mode
// passes through untouched. Cosine and sine come from a 30-stage CORDIC
// pipeline, one micro-rotation per stage; the complex multiply is rounded
// half up and saturated to the SAMPLE_BITS signed range. The pipeline has
// 4 angle stages, 30 CORDIC stages and 5 multiply/round stages from input
// transaction to result. A new pair is taken every cycle; the whole
// pipeline holds while the result register is full and not taken, so
// coef.ready follows rot.ready combinationally. Program phase_angle
// (offset 0x0) and direction_negative (offset 0x4) only while the pipe is
// empty.
module fourier_mode_phase_rotator
	import fmpr_pkg::*;
#(
	parameter int MODE_COUNT  = MODE_COUNT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	fmpr_coef_if.sink             coef,
	fmpr_rot_if.source            rot
);
	`include "fourier_mode_phase_rotator_defines.svh"

	localparam int RED_W = (MODE_COUNT >= (1 << MODE_W)) ? MODE_W : $clog2(MODE_COUNT);

	typedef enum logic {
		REG_PHASE = 1'b0,
		REG_DIR   = 1'b1
	} reg_idx_t;

	// config registers
	logic [ANG_W-1:0] phase_angle_q;
	logic             direction_negative_q;
	reg_idx_t         reg_sel;

	assign reg_sel = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_angle_q        <= '0;
			direction_negative_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_PHASE: phase_angle_q        <= pwdata[ANG_W-1:0];
				REG_DIR:   direction_negative_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PHASE: prdata = APB_DATA_W'(phase_angle_q);
			REG_DIR:   prdata = APB_DATA_W'(direction_negative_q);
		endcase
	end

	// pipeline advance
	logic en;
	assign en         = !rot.valid || rot.ready;
	assign coef.ready = en;

	logic                          vld_s1, vld_s2, vld_s3;
	logic [MODE_W-1:0]             mode_s1;
	logic [RED_W-1:0]              modr_s2;
	logic [ANG_W-1:0]              theta_s3;
	logic                          mean_s3;
	logic signed [SAMPLE_BITS-1:0] re_s1, im_s1, re_s2, im_s2, re_s3, im_s3, re_s4, im_s4;
	fmpr_tag_t                     tag_s4;
	logic signed [Z_W-1:0]         z_s4;
	logic                          flip_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			tag_s4 <= '0;
		end else if (en) begin
			vld_s1           <= coef.valid;
			vld_s2           <= vld_s1;
			vld_s3           <= vld_s2;
			tag_s4.valid     <= vld_s3;
			tag_s4.mean_mode <= mean_s3;
		end
	end

	// mode modulo MODE_COUNT: reciprocal estimate, then one correction
	if (MODE_COUNT < (1 << MODE_W)) begin : g_wrap
		localparam int RECIP = (1 << MODE_W) / MODE_COUNT;

		logic [2*MODE_W-1:0] qprod, back;
		logic [MODE_W-1:0]   quot_s1;
		logic [MODE_W:0]     rem, rem_fix;

		assign qprod   = (2*MODE_W)'(coef.mode_number) * (2*MODE_W)'(RECIP);
		assign back    = (2*MODE_W)'(quot_s1) * (2*MODE_W)'(MODE_COUNT);
		assign rem     = {1'b0, mode_s1} - back[MODE_W:0];
		assign rem_fix = (rem >= (MODE_W+1)'(MODE_COUNT)) ?
			rem - (MODE_W+1)'(MODE_COUNT) : rem;

		always_ff @(posedge clk) begin
			if (en) begin
				quot_s1 <= qprod[2*MODE_W-1:MODE_W];
				modr_s2 <= rem_fix[RED_W-1:0];
			end
		end
	end else begin : g_nowrap
		always_ff @(posedge clk) begin
			if (en) begin
				modr_s2 <= mode_s1;
			end
		end
	end

	// angle negate and fold into [-1/4, +1/4] turn
	logic [ANG_W-1:0]      theta_dir;
	logic signed [Z_W-1:0] z_raw, z_fold;
	logic                  flip;

	assign theta_dir = direction_negative_q ? (ANG_W'(0) - theta_s3) : theta_s3;
	assign z_raw     = Z_W'(signed'(theta_dir));

	always_comb begin
		priority if (z_raw > QUARTER_TURN) begin
			z_fold = z_raw - HALF_TURN;
			flip   = 1'b1;
		end else if (z_raw < -QUARTER_TURN) begin
			z_fold = z_raw + HALF_TURN;
			flip   = 1'b1;
		end else begin
			z_fold = z_raw;
			flip   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= coef.mode_number;
			re_s1    <= coef.real_part;
			im_s1    <= coef.imag_part;
			re_s2    <= re_s1;
			im_s2    <= im_s1;
			theta_s3 <= ANG_W'(ANG_W'(modr_s2) * phase_angle_q);
			mean_s3  <= (modr_s2 == '0);
			re_s3    <= re_s2;
			im_s3    <= im_s2;
			z_s4     <= z_fold;
			flip_s4  <= flip;
			re_s4    <= re_s3;
			im_s4    <= im_s3;
		end
	end

	// samples ride alongside the CORDIC stages
	logic signed [SAMPLE_BITS-1:0] re_dl_s [CORDIC_STEPS];
	logic signed [SAMPLE_BITS-1:0] im_dl_s [CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			re_dl_s[0] <= re_s4;
			im_dl_s[0] <= im_s4;
			for (int k = 1; k < CORDIC_STEPS; k++) begin
				re_dl_s[k] <= re_dl_s[k-1];
				im_dl_s[k] <= im_dl_s[k-1];
			end
		end
	end

	fmpr_tag_t              tag_c;
	logic signed [CS_W-1:0] x_c, y_c;
	logic                   flip_c;

	fmpr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_in   (tag_s4),
		.z_in     (z_s4),
		.flip_in  (flip_s4),
		.tag_out  (tag_c),
		.x_out    (x_c),
		.y_out    (y_c),
		.flip_out (flip_c)
	);

	fmpr_cmac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cmac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tag_in    (tag_c),
		.x_in      (x_c),
		.y_in      (y_c),
		.flip_in   (flip_c),
		.re_in     (re_dl_s[CORDIC_STEPS-1]),
		.im_in     (im_dl_s[CORDIC_STEPS-1]),
		.valid_out (rot.valid),
		.real_out  (rot.rotated_real),
		.imag_out  (rot.rotated_imag)
	);

	`FMPR_ASSERT_NOW(a_mode_wrapped, clk, arst_n, vld_s2, modr_s2 < MODE_COUNT)
	`FMPR_ASSERT_NOW(a_fold_range, clk, arst_n, tag_s4.valid, (z_s4 <= QUARTER_TURN) && (z_s4 >= -QUARTER_TURN))
	`FMPR_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, $stable(vld_s3) && $stable(theta_s3) && $stable(tag_s4))
endmodule
